[rtl/core/ast_pkg.sv]
// Package of shared types, codes and character helpers for the assembly source tokenizer.
`timescale 1ns / 1ps

package ast_pkg;

	localparam int AST_MAX_TEXT_CHARS = 8;
	localparam int AST_NUMBER_BITS    = 32;
	localparam int AST_LINE_BITS      = 16;

	typedef enum logic [3:0] {
		TK_NEWLINE   = 4'd0,
		TK_COMMA     = 4'd1,
		TK_LBRACK    = 4'd2,
		TK_RBRACK    = 4'd3,
		TK_PLUS      = 4'd4,
		TK_COLON     = 4'd5,
		TK_MINUS     = 4'd6,
		TK_NUM       = 4'd7,
		TK_DIRECTIVE = 4'd8,
		TK_REG       = 4'd9,
		TK_IDENT     = 4'd10,
		TK_EOF       = 4'd11,
		TK_ERROR     = 4'd12
	} token_kind_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_COMMENT,
		M_ZERO,
		M_ZERO_X,
		M_HEX,
		M_OCT,
		M_DEC,
		M_DIRECTIVE,
		M_IDENT,
		M_ERROR
	} scan_mode_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UR    = 8'h52;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_USCR  = 8'h5F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	// Returns {hex digit flag, digit value}.
	function automatic logic [4:0] char_digit(input logic [7:0] c);
		logic [7:0] v;
		logic       ok;
		v  = 8'd0;
		ok = 1'b0;
		if (is_digit(c)) begin
			v  = c - CH_0;
			ok = 1'b1;
		end else if ((c >= CH_LA) && (c <= CH_LF_HEX)) begin
			v  = c - CH_LA + 8'd10;
			ok = 1'b1;
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			v  = c - CH_UA + 8'd10;
			ok = 1'b1;
		end
		return {ok, v[3:0]};
	endfunction

endpackage

[rtl/core/ast_byte_if.sv]
// Channel interface that carries one source byte per item.
`timescale 1ns / 1ps

interface ast_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

[rtl/core/ast_token_if.sv]
// Channel interface that carries one token per item.
`timescale 1ns / 1ps

interface ast_token_if import ast_pkg::*; #(
	parameter int MAX_TEXT_CHARS = AST_MAX_TEXT_CHARS,
	parameter int NUMBER_BITS    = AST_NUMBER_BITS,
	parameter int LINE_BITS      = AST_LINE_BITS
);
	logic                        valid;
	logic                        ready;
	token_kind_t                 token_kind;
	logic [NUMBER_BITS-2:0]      number_value;
	logic [2:0]                  register_number;
	logic [8*MAX_TEXT_CHARS-1:0] text_chars;
	logic [3:0]                  text_length;
	logic [LINE_BITS-1:0]        line_number;
	logic                        last_of_run;

	modport source (output valid, output token_kind, output number_value,
		output register_number, output text_chars, output text_length,
		output line_number, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input number_value,
		input register_number, input text_chars, input text_length,
		input line_number, input last_of_run, output ready);
endinterface

[rtl/core/ast_scan.sv]
// Scanner state machine: holds the lexer state and forms the tokens that one byte completes.
`timescale 1ns / 1ps

module ast_scan import ast_pkg::*; #(
	parameter int MAX_TEXT_CHARS = AST_MAX_TEXT_CHARS,
	parameter int NUMBER_BITS    = AST_NUMBER_BITS,
	parameter int LINE_BITS      = AST_LINE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [7:0]                  ch,
	output token_kind_t                 tok_kind [3],
	output logic [NUMBER_BITS-2:0]      tok_num [3],
	output logic [2:0]                  tok_reg [3],
	output logic [8*MAX_TEXT_CHARS-1:0] tok_text [3],
	output logic [3:0]                  tok_len [3],
	output logic [1:0]                  n_tok,
	output logic [LINE_BITS-1:0]        line
);

	localparam int TEXT_W = 8 * MAX_TEXT_CHARS;
	localparam int NB     = NUMBER_BITS;
	localparam logic [NB-1:0] NUM_MAX = {1'b0, {(NB-1){1'b1}}};

	scan_mode_t           mode_q, m_d;
	logic [NB-1:0]        acc_q, acc_d;
	logic [TEXT_W-1:0]    text_q, text_d;
	logic [3:0]           tcnt_q, tcnt_d;
	logic [LINE_BITS-1:0] line_q, line_d;

	logic [4:0]        dig;
	logic [4:0]        dig_base;
	logic              dig_ok;
	logic              alnum;
	logic              room;
	logic [TEXT_W-1:0] text_app;
	logic [NB+3:0]     acc_mul;
	logic [NB+4:0]     acc_sum;
	logic [NB-1:0]     acc_next;

	token_kind_t       word_kind;
	logic [2:0]        word_reg;

	logic [1:0]        a_n;
	token_kind_t       a0_kind;
	logic [NB-2:0]     a0_num;
	logic [2:0]        a0_reg;
	logic [TEXT_W-1:0] a0_text;
	logic [3:0]        a0_len;
	logic              b_v;
	token_kind_t       b_kind;
	logic              to_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= '0;
			text_q <= '0;
			tcnt_q <= '0;
			line_q <= LINE_BITS'(1);
		end else if (take) begin
			mode_q <= m_d;
			acc_q  <= acc_d;
			text_q <= text_d;
			tcnt_q <= tcnt_d;
			line_q <= line_d;
		end
	end

	always_comb begin
		dig   = char_digit(ch);
		alnum = is_alpha(ch) || is_digit(ch);
		room  = tcnt_q < 4'(MAX_TEXT_CHARS);
		case (mode_q)
			M_HEX:          dig_base = 5'd16;
			M_OCT, M_ZERO:  dig_base = 5'd8;
			default:        dig_base = 5'd10;
		endcase
		dig_ok = dig[4] && ({1'b0, dig[3:0]} < dig_base);

		text_app = text_q;
		for (int i = 0; i < MAX_TEXT_CHARS; i++) begin
			if (tcnt_q == 4'(i)) begin
				text_app[8*i +: 8] = ch;
			end
		end

		case (mode_q)
			M_HEX:   acc_mul = {acc_q, 4'b0000};
			M_OCT:   acc_mul = {1'b0, acc_q, 3'b000};
			default: acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		endcase
		acc_sum = {1'b0, acc_mul} + (NB+5)'(dig[3:0]);
		if (acc_sum > (NB+5)'(NUM_MAX)) begin
			acc_next = NUM_MAX;
		end else begin
			acc_next = acc_sum[NB-1:0];
		end

		if ((tcnt_q == 4'd2) && ((text_q[7:0] == CH_UR) || (text_q[7:0] == CH_LR))
				&& (text_q[15:8] >= CH_0) && (text_q[15:8] <= CH_7)) begin
			word_kind = TK_REG;
			word_reg  = text_q[10:8];
		end else begin
			word_kind = TK_IDENT;
			word_reg  = 3'd0;
		end
	end

	always_comb begin
		m_d     = mode_q;
		acc_d   = acc_q;
		text_d  = text_q;
		tcnt_d  = tcnt_q;
		line_d  = line_q;
		a_n     = 2'd0;
		a0_kind = TK_NUM;
		a0_num  = '0;
		a0_reg  = 3'd0;
		a0_text = '0;
		a0_len  = 4'd0;
		b_v     = 1'b0;
		b_kind  = TK_EOF;
		to_idle = 1'b1;

		case (mode_q)
			M_COMMENT: begin
				to_idle = (ch == CH_NUL) || (ch == CH_LF);
			end
			M_ERROR: begin
				to_idle = 1'b0;
				if (ch == CH_NUL) begin
					m_d    = M_IDLE;
					acc_d  = '0;
					text_d = '0;
					tcnt_d = 4'd0;
					line_d = LINE_BITS'(1);
				end
			end
			M_ZERO: begin
				if ((ch == CH_LX) || (ch == CH_UX)) begin
					m_d     = M_ZERO_X;
					text_d  = TEXT_W'(ch);
					tcnt_d  = 4'd1;
					to_idle = 1'b0;
				end else if (dig_ok) begin
					m_d     = M_OCT;
					acc_d   = NB'(dig[3:0]);
					to_idle = 1'b0;
				end else begin
					a_n = 2'd1;
				end
			end
			M_ZERO_X: begin
				if (dig[4]) begin
					m_d     = M_HEX;
					acc_d   = NB'(dig[3:0]);
					text_d  = '0;
					tcnt_d  = 4'd0;
					to_idle = 1'b0;
				end else begin
					// The zero goes out as a number; the x opens an identifier.
					a_n = 2'd1;
					m_d = M_IDENT;
					if ((alnum || (ch == CH_USCR)) && room) begin
						text_d  = text_app;
						tcnt_d  = tcnt_q + 4'd1;
						to_idle = 1'b0;
					end else begin
						a_n = 2'd2;
					end
				end
			end
			M_HEX, M_OCT, M_DEC: begin
				if (dig_ok) begin
					acc_d   = acc_next;
					to_idle = 1'b0;
				end else begin
					a_n    = 2'd1;
					a0_num = acc_q[NB-2:0];
				end
			end
			M_DIRECTIVE: begin
				if (alnum && room) begin
					text_d  = text_app;
					tcnt_d  = tcnt_q + 4'd1;
					to_idle = 1'b0;
				end else begin
					a_n     = 2'd1;
					a0_kind = TK_DIRECTIVE;
					a0_text = text_q;
					a0_len  = tcnt_q;
				end
			end
			M_IDENT: begin
				if ((alnum || (ch == CH_USCR)) && room) begin
					text_d  = text_app;
					tcnt_d  = tcnt_q + 4'd1;
					to_idle = 1'b0;
				end else begin
					a_n     = 2'd1;
					a0_kind = word_kind;
					a0_reg  = word_reg;
					a0_text = text_q;
					a0_len  = tcnt_q;
				end
			end
			default: begin
			end
		endcase

		if (to_idle) begin
			m_d = M_IDLE;
			case (ch)
				CH_NUL: begin
					b_v    = 1'b1;
					b_kind = TK_EOF;
					acc_d  = '0;
					text_d = '0;
					tcnt_d = 4'd0;
					line_d = LINE_BITS'(1);
				end
				CH_LF: begin
					b_v    = 1'b1;
					b_kind = TK_NEWLINE;
					if (line_q != {LINE_BITS{1'b1}}) begin
						line_d = line_q + LINE_BITS'(1);
					end
				end
				CH_SEMI: m_d = M_COMMENT;
				CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: begin
				end
				CH_COMMA: begin
					b_v    = 1'b1;
					b_kind = TK_COMMA;
				end
				CH_LBRK: begin
					b_v    = 1'b1;
					b_kind = TK_LBRACK;
				end
				CH_RBRK: begin
					b_v    = 1'b1;
					b_kind = TK_RBRACK;
				end
				CH_PLUS: begin
					b_v    = 1'b1;
					b_kind = TK_PLUS;
				end
				CH_COLON: begin
					b_v    = 1'b1;
					b_kind = TK_COLON;
				end
				CH_MINUS: begin
					b_v    = 1'b1;
					b_kind = TK_MINUS;
				end
				CH_DOT: begin
					m_d    = M_DIRECTIVE;
					text_d = '0;
					tcnt_d = 4'd0;
				end
				default: begin
					if (ch == CH_0) begin
						m_d   = M_ZERO;
						acc_d = '0;
					end else if (is_digit(ch)) begin
						m_d   = M_DEC;
						acc_d = NB'(dig[3:0]);
					end else if (is_alpha(ch) || (ch == CH_USCR)) begin
						m_d    = M_IDENT;
						text_d = TEXT_W'(ch);
						tcnt_d = 4'd1;
					end else begin
						b_v    = 1'b1;
						b_kind = TK_ERROR;
						m_d    = M_ERROR;
					end
				end
			endcase
		end
	end

	// Tokens leave in the order: pending token, identifier after a bare zero-x, byte's own token.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tok_kind[i] = b_kind;
			tok_num[i]  = '0;
			tok_reg[i]  = 3'd0;
			tok_text[i] = '0;
			tok_len[i]  = 4'd0;
		end
		if (a_n != 2'd0) begin
			tok_kind[0] = a0_kind;
			tok_num[0]  = a0_num;
			tok_reg[0]  = a0_reg;
			tok_text[0] = a0_text;
			tok_len[0]  = a0_len;
		end
		if (a_n == 2'd2) begin
			tok_kind[1] = word_kind;
			tok_reg[1]  = word_reg;
			tok_text[1] = text_q;
			tok_len[1]  = tcnt_q;
		end
		n_tok = a_n + {1'b0, b_v};
		line  = line_q;
	end

endmodule

[rtl/core/assembly_source_tokenizer_top.sv]
// Top level of the assembly source tokenizer: scanner, token group register and output register.
`timescale 1ns / 1ps

// Takes one source byte per cycle and returns its tokens one per cycle on the token channel,
// while the token channel is ready and each byte completes at most one token. A byte that
// completes n tokens (at most three) holds the byte channel until the group register that
// holds them has fed all n to the single output register, one token a cycle. The first
// token of a byte passes the group register, then the output register. A zero byte ends the
// source, emits eof unless the scanner was in error, and resets the scanner for the next source.

module assembly_source_tokenizer_top import ast_pkg::*; #(
	parameter int MAX_TEXT_CHARS = AST_MAX_TEXT_CHARS,
	parameter int NUMBER_BITS    = AST_NUMBER_BITS,
	parameter int LINE_BITS      = AST_LINE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	ast_byte_if.sink      byte_in,
	ast_token_if.source   token_out
);

	localparam int TEXT_W = 8 * MAX_TEXT_CHARS;

	token_kind_t          sc_kind [3];
	logic [NUMBER_BITS-2:0] sc_num [3];
	logic [2:0]           sc_reg [3];
	logic [TEXT_W-1:0]    sc_text [3];
	logic [3:0]           sc_len [3];
	logic [1:0]           sc_n;
	logic [LINE_BITS-1:0] sc_line;

	token_kind_t          grp_kind_s1 [3];
	logic [NUMBER_BITS-2:0] grp_num_s1 [3];
	logic [2:0]           grp_reg_s1 [3];
	logic [TEXT_W-1:0]    grp_text_s1 [3];
	logic [3:0]           grp_len_s1 [3];
	logic [LINE_BITS-1:0] grp_line_s1;
	logic [1:0]           grp_rem_s1;

	logic                 o_valid_q;
	token_kind_t          o_kind_q;
	logic [NUMBER_BITS-2:0] o_num_q;
	logic [2:0]           o_reg_q;
	logic [TEXT_W-1:0]    o_text_q;
	logic [3:0]           o_len_q;
	logic [LINE_BITS-1:0] o_line_q;
	logic                 o_last_q;

	logic mov;
	logic grp_free;
	logic take;

	assign mov      = (grp_rem_s1 != 2'd0) && (!o_valid_q || token_out.ready);
	assign grp_free = (grp_rem_s1 == 2'd0) || ((grp_rem_s1 == 2'd1) && mov);
	assign take     = byte_in.valid && grp_free;
	assign byte_in.ready = grp_free;

	ast_scan #(
		.MAX_TEXT_CHARS (MAX_TEXT_CHARS),
		.NUMBER_BITS    (NUMBER_BITS),
		.LINE_BITS      (LINE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ch       (byte_in.ch),
		.tok_kind (sc_kind),
		.tok_num  (sc_num),
		.tok_reg  (sc_reg),
		.tok_text (sc_text),
		.tok_len  (sc_len),
		.n_tok    (sc_n),
		.line     (sc_line)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_rem_s1 <= 2'd0;
		end else if (take) begin
			grp_rem_s1 <= sc_n;
		end else if (mov) begin
			grp_rem_s1 <= grp_rem_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp_kind_s1 <= sc_kind;
			grp_num_s1  <= sc_num;
			grp_reg_s1  <= sc_reg;
			grp_text_s1 <= sc_text;
			grp_len_s1  <= sc_len;
			grp_line_s1 <= sc_line;
		end else if (mov) begin
			for (int i = 0; i < 2; i++) begin
				grp_kind_s1[i] <= grp_kind_s1[i+1];
				grp_num_s1[i]  <= grp_num_s1[i+1];
				grp_reg_s1[i]  <= grp_reg_s1[i+1];
				grp_text_s1[i] <= grp_text_s1[i+1];
				grp_len_s1[i]  <= grp_len_s1[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (mov) begin
			o_valid_q <= 1'b1;
		end else if (token_out.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mov) begin
			o_kind_q <= grp_kind_s1[0];
			o_num_q  <= grp_num_s1[0];
			o_reg_q  <= grp_reg_s1[0];
			o_text_q <= grp_text_s1[0];
			o_len_q  <= grp_len_s1[0];
			o_line_q <= grp_line_s1;
			o_last_q <= (grp_rem_s1 == 2'd1);
		end
	end

	assign token_out.valid           = o_valid_q;
	assign token_out.token_kind      = o_kind_q;
	assign token_out.number_value    = o_num_q;
	assign token_out.register_number = o_reg_q;
	assign token_out.text_chars      = o_text_q;
	assign token_out.text_length     = o_len_q;
	assign token_out.line_number     = o_line_q;
	assign token_out.last_of_run     = o_last_q;

`ifndef SYNTH
	a_num_only_on_num: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && (o_kind_q != TK_NUM) |-> (o_num_q == '0))
		else $error("number value set on a token that is not a number");

	a_reg_only_on_reg: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && (o_kind_q != TK_REG) |-> (o_reg_q == 3'd0))
		else $error("register number set on a token that is not a register");

	a_text_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> (o_len_q <= 4'(MAX_TEXT_CHARS)))
		else $error("text length beyond the text buffer");

	a_group_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		take && (sc_n != 2'd0) |=> (grp_rem_s1 != 2'd0))
		else $error("tokens of an accepted byte were lost");
`endif

endmodule
